// File: rtl/core/buffer_pool_slot_replacement_defines.svh
// Assertion macros for the buffer pool slot replacement block.
`ifndef BUFFER_POOL_SLOT_REPLACEMENT_DEFINES_SVH
`define BUFFER_POOL_SLOT_REPLACEMENT_DEFINES_SVH

// Clocked assertion, masked while reset is high.
`define BPSR_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define BPSR_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/bpsr_pkg.sv
// Shared types and constants of the buffer pool slot replacement block.
package bpsr_pkg;

   localparam int OP_W   = 2;
   localparam int PAGE_W = 32;
   localparam int SLOT_W = 4;
   localparam int TIME_W = 48;
   localparam int OUTC_W = 3;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP   = 2'd0,
      OP_TOUCH_RD = 2'd1,
      OP_TOUCH_WR = 2'd2,
      OP_INVAL    = 2'd3
   } op_type;

   typedef enum logic [OUTC_W-1:0] {
      OUT_HIT      = 3'd0,
      OUT_INVALID  = 3'd1,
      OUT_CLOCK    = 3'd2,
      OUT_LRU      = 3'd3,
      OUT_FALLBACK = 3'd4,
      OUT_DONE     = 3'd5
   } outcome_type;

   // one slot as held in the slot memory; valid bits live in flip-flops
   typedef struct packed {
      logic              used;
      logic              dirty;
      logic [PAGE_W-1:0] page;
      logic [TIME_W-1:0] acc_time;
   } entry_type;

   typedef struct packed {
      logic start;   // new lookup, clear candidate trackers
      logic step;    // one slot's data is on the memory output
   } scan_ctl_type;

   typedef struct packed {
      logic              hit;         // this slot holds the page
      logic              advance;     // clock hand moves past this slot
      logic              clear_used;  // write back this slot with used cleared
      outcome_type       kind;        // replacement choice so far
      logic [PAGE_W-1:0] victim_page;
      logic              victim_wb;
   } scan_stat_type;

endpackage

// File: rtl/core/bpsr_ram.sv
// Generic simple dual-port RAM with registered read.
module bpsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/bpsr_scan.sv
// Candidate tracker: hit test, clock, invalid and LRU choice, one slot per step.
module bpsr_scan import bpsr_pkg::*; #(
   parameter int SLOTS = 16,
   localparam int IW = $clog2(SLOTS)
) (
   input  logic              clock,
   input  logic              reset,
   input  scan_ctl_type      ctl,
   input  logic [IW-1:0]     slot_addr,
   input  entry_type         entry,      // zero when the slot is invalid
   input  logic              slot_ok,    // slot valid
   input  logic [PAGE_W-1:0] page,
   output scan_stat_type     stat,
   output logic [IW-1:0]     final_slot
);

   logic [IW-1:0]     cand_ff, cand_in;
   outcome_type       kind_ff, kind_in;
   logic              have_clk_ff, have_clk_in;
   logic              have_lru_ff, have_lru_in;
   logic [IW-1:0]     lru_slot_ff, lru_slot_in;
   logic [TIME_W-1:0] lru_time_ff, lru_time_in;
   logic [PAGE_W-1:0] lru_page_ff, lru_page_in;
   logic              lru_wb_ff, lru_wb_in;
   logic [PAGE_W-1:0] cand_page_ff, cand_page_in;
   logic              cand_wb_ff, cand_wb_in;
   logic              match;

   always_comb begin
      match        = slot_ok && (entry.page == page);
      cand_in      = cand_ff;
      kind_in      = kind_ff;
      have_clk_in  = have_clk_ff;
      have_lru_in  = have_lru_ff;
      lru_slot_in  = lru_slot_ff;
      lru_time_in  = lru_time_ff;
      lru_page_in  = lru_page_ff;
      lru_wb_in    = lru_wb_ff;
      cand_page_in = cand_page_ff;
      cand_wb_in   = cand_wb_ff;
      if (ctl.start) begin
         cand_in      = '0;
         kind_in      = OUT_FALLBACK;
         have_clk_in  = 1'b0;
         have_lru_in  = 1'b0;
         lru_slot_in  = '0;
         lru_time_in  = '0;
         lru_page_in  = '0;
         lru_wb_in    = 1'b0;
         cand_page_in = '0;
         cand_wb_in   = 1'b0;
      end else if (ctl.step && !match) begin
         if (!have_clk_ff && !entry.used) begin
            cand_in      = slot_addr;
            kind_in      = OUT_CLOCK;
            have_clk_in  = 1'b1;
            cand_page_in = entry.page;
            cand_wb_in   = slot_ok && entry.dirty;
         end
         // an empty slot beats any clock choice
         if ((kind_ff != OUT_INVALID) && !slot_ok) begin
            cand_in      = slot_addr;
            kind_in      = OUT_INVALID;
            have_clk_in  = 1'b1;
            cand_page_in = entry.page;
            cand_wb_in   = 1'b0;
         end
         // strict less-than keeps the first in scan order on ties
         if (slot_ok && (!have_lru_ff || (entry.acc_time < lru_time_ff))) begin
            have_lru_in = 1'b1;
            lru_slot_in = slot_addr;
            lru_time_in = entry.acc_time;
            lru_page_in = entry.page;
            lru_wb_in   = entry.dirty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff     <= OUT_FALLBACK;
         have_clk_ff <= 1'b0;
         have_lru_ff <= 1'b0;
      end else begin
         kind_ff     <= kind_in;
         have_clk_ff <= have_clk_in;
         have_lru_ff <= have_lru_in;
      end
      cand_ff      <= cand_in;
      lru_slot_ff  <= lru_slot_in;
      lru_time_ff  <= lru_time_in;
      lru_page_ff  <= lru_page_in;
      lru_wb_ff    <= lru_wb_in;
      cand_page_ff <= cand_page_in;
      cand_wb_ff   <= cand_wb_in;
   end

   always_comb begin
      stat.hit        = ctl.step && match;
      stat.advance    = ctl.step && !match && !have_clk_ff;
      stat.clear_used = ctl.step && !match && !have_clk_ff && entry.used;
      if ((kind_ff == OUT_FALLBACK) && have_lru_ff) begin
         stat.kind        = OUT_LRU;
         stat.victim_page = lru_page_ff;
         stat.victim_wb   = lru_wb_ff;
         final_slot       = lru_slot_ff;
      end else begin
         stat.kind        = kind_ff;
         stat.victim_page = cand_page_ff;
         stat.victim_wb   = cand_wb_ff;
         final_slot       = cand_ff;
      end
   end

endmodule

// File: rtl/core/buffer_pool_slot_replacement.sv
// Buffer pool slot manager: clock replacement with LRU fallback over a slot memory.
// Lookup: accept, scan the slots (one memory read per slot), then on a miss install in the
//   finish state; the result is registered once the output register is free.
//   A hit ends the scan early at the matching slot. Touch/invalidate: accept and read the slot,
//   then finish and load the result. A new request is accepted only in idle, one item at a time.
// Reset clears valid bits, scan pointer and control; memory contents are masked, not cleared.
`include "buffer_pool_slot_replacement_defines.svh"

module buffer_pool_slot_replacement import bpsr_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // page_id[31:0], slot_index[35:32], timestamp[83:36]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // chosen_slot[3:0], victim_page_id[35:4],
                                    // writeback_needed[36]
   output logic [2:0]  rsp_tuser    // outcome[2:0]
);

   localparam int IW = $clog2(SLOTS);
   // compare width wide enough for both the slot index field and SLOTS itself
   localparam int WW = ((IW + 1) > SLOT_W) ? (IW + 1) : SLOT_W;
   localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
      return (a == LAST_SLOT) ? '0 : a + 1'b1;
   endfunction

   // request fields
   logic [PAGE_W-1:0] req_page;
   logic [SLOT_W-1:0] req_idx;
   logic [TIME_W-1:0] req_ts;
   logic              req_fire;

   assign req_page = req_tdata[31:0];
   assign req_idx  = req_tdata[35:32];
   assign req_ts   = req_tdata[83:36];
   assign req_fire = req_tvalid && req_tready;

   // control and item registers
   state_type         state_ff, state_in;
   logic [IW-1:0]     ptr_ff, ptr_in;        // clock hand
   logic [IW-1:0]     addr_ff, addr_in;      // slot whose data is on the memory output
   logic [IW-1:0]     cnt_ff, cnt_in;        // slots evaluated so far in this scan
   logic              hit_ff, hit_in;
   logic [IW-1:0]     hit_slot_ff, hit_slot_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   op_type            op_ff;
   logic [PAGE_W-1:0] page_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic [TIME_W-1:0] ts_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   outcome_type       rsp_kind_ff, rsp_kind_in;
   logic [PAGE_W-1:0] rsp_victim_ff, rsp_victim_in;
   logic              rsp_wb_ff, rsp_wb_in;

   // memory port
   logic              mem_we, mem_re;
   logic [IW-1:0]     mem_waddr, mem_raddr;
   entry_type         mem_wdata, mem_q, rd_entry;
   logic              rd_ok;

   // scan unit
   scan_ctl_type      scan_ctl;
   scan_stat_type     scan_stat;
   logic [IW-1:0]     scan_slot;

   logic              out_free;
   logic              idx_in_range;

   assign rd_ok    = valid_ff[addr_ff];
   assign rd_entry = rd_ok ? mem_q : '0;           // an empty slot reads as all zero
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign idx_in_range = (WW'(idx_ff) < WW'(SLOTS));
   assign req_tready = (state_ff == ST_IDLE);

   bpsr_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOTS)
   ) u_slot_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_q)
   );

   bpsr_scan #(
      .SLOTS (SLOTS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .slot_addr  (addr_ff),
      .entry      (rd_entry),
      .slot_ok    (rd_ok),
      .page       (page_ff),
      .stat       (scan_stat),
      .final_slot (scan_slot)
   );

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_victim_in = rsp_victim_ff;
      rsp_wb_in     = rsp_wb_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = rd_entry;
      mem_re        = 1'b0;
      mem_raddr     = addr_ff;
      scan_ctl      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mem_re = 1'b1;
               cnt_in = '0;
               hit_in = 1'b0;
               if (op_type'(req_tuser) == OP_LOOKUP) begin
                  mem_raddr      = ptr_ff;
                  addr_in        = ptr_ff;
                  scan_ctl.start = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  mem_raddr = IW'(req_idx);
                  addr_in   = IW'(req_idx);
                  state_in  = ST_FINISH;
               end
            end
         end

         ST_SCAN: begin
            scan_ctl.step = 1'b1;
            if (scan_stat.hit) begin
               // touch the hit slot in place and end the scan
               mem_we             = 1'b1;
               mem_wdata.used     = 1'b1;
               mem_wdata.acc_time = ts_ff;
               hit_in             = 1'b1;
               hit_slot_in        = addr_ff;
               state_in           = ST_FINISH;
            end else begin
               if (scan_stat.clear_used) begin
                  mem_we         = 1'b1;
                  mem_wdata.used = 1'b0;
               end
               if (scan_stat.advance) begin
                  ptr_in = wrap_inc(ptr_ff);
               end
               if (cnt_ff == LAST_SLOT) begin
                  state_in = ST_FINISH;
               end else begin
                  // next slot's read never collides with this slot's write-back
                  cnt_in    = cnt_ff + 1'b1;
                  addr_in   = wrap_inc(addr_ff);
                  mem_re    = 1'b1;
                  mem_raddr = wrap_inc(addr_ff);
               end
            end
         end

         ST_FINISH: begin
            // the side effects of this state happen in the cycle the result is loaded
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = idx_ff;
               rsp_kind_in   = OUT_DONE;
               rsp_victim_in = '0;
               rsp_wb_in     = 1'b0;
               state_in      = ST_IDLE;
               case (op_ff)
                  OP_LOOKUP: begin
                     if (hit_ff) begin
                        rsp_slot_in = SLOT_W'(hit_slot_ff);
                        rsp_kind_in = OUT_HIT;
                     end else begin
                        mem_we              = 1'b1;
                        mem_waddr           = scan_slot;
                        mem_wdata.used      = 1'b1;
                        mem_wdata.dirty     = 1'b0;
                        mem_wdata.page      = page_ff;
                        mem_wdata.acc_time  = ts_ff;
                        valid_in[scan_slot] = 1'b1;
                        rsp_slot_in         = SLOT_W'(scan_slot);
                        rsp_kind_in         = scan_stat.kind;
                        rsp_victim_in       = scan_stat.victim_page;
                        rsp_wb_in           = scan_stat.victim_wb;
                     end
                  end
                  OP_INVAL: begin
                     if (idx_in_range) begin
                        valid_in[addr_ff] = 1'b0;
                        rsp_victim_in     = rd_entry.page;
                        rsp_wb_in         = rd_ok && rd_entry.dirty;
                     end
                  end
                  default: begin
                     // touch read or touch write on a valid slot
                     if (idx_in_range && rd_ok) begin
                        mem_we             = 1'b1;
                        mem_wdata.used     = 1'b1;
                        mem_wdata.dirty    = rd_entry.dirty || (op_ff == OP_TOUCH_WR);
                        mem_wdata.acc_time = ts_ff;
                     end
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         hit_ff       <= hit_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      hit_slot_ff   <= hit_slot_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_victim_ff <= rsp_victim_in;
      rsp_wb_ff     <= rsp_wb_in;
      if (req_fire) begin
         op_ff   <= op_type'(req_tuser);
         page_ff <= req_page;
         idx_ff  <= req_idx;
         ts_ff   <= req_ts;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_wb_ff, rsp_victim_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_kind_ff;

   // a read and a write in the same cycle never touch the same slot
   `BPSR_ASSERT(a_no_rw_collide, clock, reset, (mem_we && mem_re) |-> (mem_waddr != mem_raddr), "slot memory read and write collide")
   // results are loaded only from the finish state
   `BPSR_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_tvalid) |-> $past(state_ff == ST_FINISH), "result loaded outside finish")
   // a hit always ends the scan
   `BPSR_ASSERT(a_hit_ends_scan, clock, reset, (state_ff == ST_SCAN) |-> !hit_ff, "scan continues after hit")
   // no result is valid after reset is held
   `BPSR_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule
